[rtl/ccl_pkg.sv]
// shared types and constants for the conditional comment line filter
// no dependencies
package ccl_pkg;

    localparam int unsigned TAG_WORDS  = 8;
    localparam int unsigned TAG_W      = 64;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned TAG_CNT_W  = 4;
    localparam int unsigned Q_DEPTH    = 4;
    localparam int unsigned Q_PTR_W    = 2;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef enum logic [2:0] {
        PH_START,
        PH_SLASH1,
        PH_SLASH2,
        PH_TAG,
        PH_PASS,
        PH_DROP
    } t_phase;

    // up to three output bytes caused by one input byte, cnt is 1..3
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] data;
    } t_act;

endpackage

[rtl/ccl_in_if.sv]
// input channel: one text byte or an end of stream mark per request
// no dependencies
interface ccl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

[rtl/ccl_out_if.sv]
// output channel: one filtered text byte per request
// no dependencies
interface ccl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

[rtl/conditional_comment_line_filter_unit.sv]
// Conditional comment line filter, top level.
// Channels: i_in takes one text byte (or an end_of_input mark) per request,
// o_out gives one filtered byte per request; last_of_run flags the final byte
// caused by an input request. Lines end in LF, CR or CRLF and leave as LF.
// Tags are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must
// write them only while idle, the block itself does not enforce it.
// Throughput: one input request per cycle while the queue has room, as long
// as each produces at most one byte; a request that yields two or three bytes
// holds the single byte output port for each of its bytes in turn.
// Path: front classifies into the queue, back output register drives o_out.
// A four entry queue between front and back absorbs bursts; when it is full
// i_in.ready drops. A stalled receiver holds o_out steady and the queue
// fills, then input stalls. Synchronous reset clears the tags to zero,
// returns to line start and empties the queue.
// Depends on ccl_pkg, ccl_in_if, ccl_out_if, ccl_front, ccl_fifo, ccl_back.
module conditional_comment_line_filter_unit #(
    parameter int unsigned NUM_TAGS      = 8,
    parameter int unsigned MAX_TAG_CHARS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ccl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ccl_pkg::TAG_W-1:0]        i_cfg_data,
    ccl_in_if.sink                           i_in,
    ccl_out_if.source                        o_out
);

    logic           push, pop, q_full, q_empty;
    ccl_pkg::t_act  act_in, act_out;

    ccl_front #(
        .NUM_TAGS      (NUM_TAGS),
        .MAX_TAG_CHARS (MAX_TAG_CHARS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_act      (act_in)
    );

    ccl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_act   (act_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_act   (act_out)
    );

    ccl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_act     (act_out),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

[rtl/ccl_front.sv]
// front part: tag registers, line state machine and byte classification
// depends on ccl_pkg and ccl_in_if
module ccl_front #(
    parameter int unsigned NUM_TAGS      = 8,
    parameter int unsigned MAX_TAG_CHARS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ccl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ccl_pkg::TAG_W-1:0]        i_cfg_data,
    ccl_in_if.sink                           i_in,
    input  logic                             i_q_full,
    output logic                             o_push,
    output ccl_pkg::t_act                    o_act
);

    localparam logic [ccl_pkg::TAG_CNT_W-1:0] MaxCnt =
        ccl_pkg::TAG_CNT_W'(MAX_TAG_CHARS);

    ccl_pkg::t_phase                  r_phase, n_phase;
    logic [ccl_pkg::TAG_W-1:0]        r_tag_buf, n_tag_buf;
    logic [ccl_pkg::TAG_CNT_W-1:0]    r_tag_cnt, n_tag_cnt;
    logic                             r_swallow, n_swallow;
    logic [ccl_pkg::TAG_W-1:0]        r_tag_word [NUM_TAGS];
    logic [NUM_TAGS-1:0]              hit;
    logic                             tag_ok;
    logic                             accept;
    logic [1:0]                       k;
    logic [2:0][7:0]                  obytes;
    logic                             line_end;
    logic                             tchar;
    logic [7:0]                       b;

    function automatic logic is_ident_char(input logic [7:0] c);
        is_ident_char = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39) ||
                        (c >= 8'h41 && c <= 8'h5A) || c == ccl_pkg::CH_UNDER;
    endfunction

    for (genvar i = 0; i < NUM_TAGS; i++) begin : g_tag
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag_word[i] <= '0;
            end else if (i_cfg_we && i_cfg_idx == ccl_pkg::CFG_IDX_W'(i)) begin
                r_tag_word[i] <= i_cfg_data;
            end
        end
        assign hit[i] = (r_tag_word[i] != '0) && (r_tag_word[i] == r_tag_buf);
    end

    assign tag_ok   = (r_tag_cnt != '0) && (r_tag_cnt <= MaxCnt) && (|hit);
    assign i_in.ready = !i_q_full;
    assign accept   = i_in.valid && !i_q_full;
    assign b        = i_in.in_byte;
    assign line_end = (b == ccl_pkg::CH_LF) || (b == ccl_pkg::CH_CR);
    assign tchar    = is_ident_char(b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ccl_pkg::PH_START;
            r_tag_buf <= '0;
            r_tag_cnt <= '0;
            r_swallow <= 1'b0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_tag_buf <= n_tag_buf;
            r_tag_cnt <= n_tag_cnt;
            r_swallow <= n_swallow;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_tag_buf = r_tag_buf;
        n_tag_cnt = r_tag_cnt;
        n_swallow = r_swallow;
        k         = 2'd0;
        obytes    = '0;
        if (i_in.end_of_input) begin
            case (r_phase)
                ccl_pkg::PH_SLASH1: begin
                    obytes[0] = ccl_pkg::CH_SLASH;
                    obytes[1] = ccl_pkg::CH_LF;
                    k = 2'd2;
                end
                ccl_pkg::PH_SLASH2: begin
                    obytes[0] = ccl_pkg::CH_SLASH;
                    obytes[1] = ccl_pkg::CH_SLASH;
                    obytes[2] = ccl_pkg::CH_LF;
                    k = 2'd3;
                end
                ccl_pkg::PH_TAG: begin
                    if (tag_ok) begin
                        obytes[0] = ccl_pkg::CH_LF;
                        k = 2'd1;
                    end
                end
                ccl_pkg::PH_PASS: begin
                    obytes[0] = ccl_pkg::CH_LF;
                    k = 2'd1;
                end
                default: begin
                end
            endcase
            n_phase   = ccl_pkg::PH_START;
            n_tag_buf = '0;
            n_tag_cnt = '0;
            n_swallow = 1'b0;
        end else if (b == ccl_pkg::CH_LF && r_swallow) begin
            n_swallow = 1'b0;
        end else begin
            n_swallow = (b == ccl_pkg::CH_CR);
            n_phase   = ccl_pkg::PH_PASS;
            case (r_phase)
                ccl_pkg::PH_START: begin
                    if (b == ccl_pkg::CH_SLASH) begin
                        n_phase = ccl_pkg::PH_SLASH1;
                    end else if (!line_end) begin
                        obytes[k] = b;
                        k = k + 2'd1;
                    end
                end
                ccl_pkg::PH_SLASH1: begin
                    if (b == ccl_pkg::CH_SLASH) begin
                        n_phase = ccl_pkg::PH_SLASH2;
                    end else begin
                        obytes[k] = ccl_pkg::CH_SLASH;
                        k = k + 2'd1;
                        if (!line_end) begin
                            obytes[k] = b;
                            k = k + 2'd1;
                        end
                    end
                end
                ccl_pkg::PH_SLASH2: begin
                    if (!line_end && tchar) begin
                        n_tag_buf = {56'd0, b};
                        n_tag_cnt = ccl_pkg::TAG_CNT_W'(1);
                        n_phase   = ccl_pkg::PH_TAG;
                    end else begin
                        obytes[k] = ccl_pkg::CH_SLASH;
                        k = k + 2'd1;
                        obytes[k] = ccl_pkg::CH_SLASH;
                        k = k + 2'd1;
                        if (!line_end) begin
                            obytes[k] = b;
                            k = k + 2'd1;
                        end
                    end
                end
                ccl_pkg::PH_TAG: begin
                    n_phase = ccl_pkg::PH_TAG;
                    if (!line_end && tchar) begin
                        if (r_tag_cnt < MaxCnt) begin
                            n_tag_buf[{r_tag_cnt[2:0], 3'b000} +: 8] = b;
                            n_tag_cnt = r_tag_cnt + ccl_pkg::TAG_CNT_W'(1);
                        end else begin
                            n_tag_cnt = MaxCnt + ccl_pkg::TAG_CNT_W'(1);
                        end
                    end else if (tag_ok) begin
                        n_phase = ccl_pkg::PH_PASS;
                        if (!line_end && b != ccl_pkg::CH_SPACE) begin
                            obytes[k] = b;
                            k = k + 2'd1;
                        end
                    end else begin
                        n_phase = ccl_pkg::PH_DROP;
                    end
                end
                ccl_pkg::PH_DROP: begin
                    n_phase = ccl_pkg::PH_DROP;
                end
                default: begin
                    if (!line_end) begin
                        obytes[k] = b;
                        k = k + 2'd1;
                    end
                end
            endcase
            if (line_end) begin
                if (r_phase != ccl_pkg::PH_DROP && n_phase != ccl_pkg::PH_DROP) begin
                    obytes[k] = ccl_pkg::CH_LF;
                    k = k + 2'd1;
                end
                n_phase = ccl_pkg::PH_START;
            end
            if (n_phase != ccl_pkg::PH_TAG) begin
                n_tag_buf = '0;
                n_tag_cnt = '0;
            end
        end
    end

    assign o_push     = accept && (k != 2'd0);
    assign o_act.cnt  = k;
    assign o_act.data = obytes;

endmodule

[rtl/ccl_fifo.sv]
// short queue of byte groups between front and back parts
// depends on ccl_pkg
module ccl_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ccl_pkg::t_act  i_act,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output ccl_pkg::t_act  o_act
);

    ccl_pkg::t_act                 r_mem [ccl_pkg::Q_DEPTH];
    logic [ccl_pkg::Q_PTR_W-1:0]   r_wr, r_rd;
    logic [ccl_pkg::Q_PTR_W:0]     r_cnt;
    logic                          do_push, do_pop;

    assign o_full  = (r_cnt == (ccl_pkg::Q_PTR_W+1)'(ccl_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_act   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (ccl_pkg::Q_PTR_W+1)'(do_push) - (ccl_pkg::Q_PTR_W+1)'(do_pop);
        end
    end

endmodule

[rtl/ccl_back.sv]
// back part: unpacks byte groups into single output bytes
// depends on ccl_pkg and ccl_out_if
module ccl_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  ccl_pkg::t_act  i_act,
    output logic           o_pop,
    ccl_out_if.source      o_out
);

    logic           r_valid;
    ccl_pkg::t_act  r_act;
    logic [1:0]     r_idx;
    logic           is_last;
    logic           take;

    assign is_last = (r_idx == r_act.cnt - 2'd1);
    assign take    = o_out.valid && o_out.ready;
    assign o_pop   = !i_q_empty && (!r_valid || (take && is_last));

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_act.data[r_idx];
    assign o_out.last_of_run = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (take) begin
            if (is_last) begin
                r_valid <= 1'b0;
            end
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_act <= i_act;
        end
    end

endmodule
